// ===== hw/rtl/lrsgd_pkg.sv =====
`default_nettype none

package lrsgd_pkg;

  // widths of the item fields
  localparam int FEAT_W  = 16;
  localparam int LR_W    = 16;
  localparam int PROB_W  = 17;
  localparam int ERR_W   = 18;
  localparam int WGT_W   = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;

  // reset values
  localparam logic [LR_W-1:0]         LR_RESET  = 16'd655;
  localparam logic signed [WGT_W-1:0] WGT_RESET = 32'sd65536;

  // sigmoid table depth
  localparam int SIG_ENTRIES_DEF = 256;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MZ0,
    ST_MZ1,
    ST_ZSUM,
    ST_ZCLP,
    ST_MIDX,
    ST_IDX,
    ST_LUT,
    ST_MG,
    ST_MD0,
    ST_MD1,
    ST_UPD
  } state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  // shift-subtract division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-a) in Q32 for a in Q16, series on a/256 then squared eight times
  function automatic logic [63:0] neg_exp_q32(input logic [63:0] a);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] v;
    if (a == 64'd0) begin
      return 64'h1_0000_0000;
    end
    y  = a << 8;
    y2 = (y * y) >> 32;
    y3 = (y2 * y) >> 32;
    v  = (64'd1 << 32) - y + (y2 >> 1) - (y3 / 64'd6);
    for (int n = 0; n < 8; n++) begin
      v = (v * v) >> 32;
    end
    return v;
  endfunction

  // sigmoid at the midpoint of table bin k, unsigned Q1.16
  function automatic logic [PROB_W-1:0] sig_entry(input int k, input int entries);
    logic [63:0] mid;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] s;
    logic        neg;
    mid = udiv64(64'(2 * k + 1) * 64'd524288, 64'(entries));
    neg = (mid < 64'd524288);
    mag = neg ? (64'd524288 - mid) : (mid - 64'd524288);
    den = (64'd1 << 32) + neg_exp_q32(mag);
    s   = udiv64((64'd1 << 48) + (den >> 1), den);
    return neg ? PROB_W'(64'd65536 - s) : PROB_W'(s);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/logistic_regression_sgd_step.sv =====
`default_nettype none

// One stochastic gradient step of two-feature logistic regression per item.
// An item (two Q1.15 features in tdata, the label in tuser) is taken when the
// block is idle; once the sequencer reaches its update step and the output is
// free, the result (probability, error and the three updated Q15.16 values) is
// loaded into the output register. A new item is taken only after that. All six
// products (two for z, one for the table index, one for lr*err, two for the
// weight deltas) run one per step through a single registered 36x17 multiplier.
// The sigmoid table is built at elaboration and read through a register. A
// result that waits at the output does not hold up the next item until its
// final step. The learning rate may be written at any idle time.
module logistic_regression_sgd_step #(
  parameter int SIG_ENTRIES = lrsgd_pkg::SIG_ENTRIES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // feature_zero [15:0], feature_one [31:16]
  input  wire logic [lrsgd_pkg::IN_DATA_W-1:0]      in_tdata,
  // label [0]
  input  wire logic                                 in_tuser,
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  // probability [16:0], error [34:17], weight_zero [66:35],
  // weight_one [98:67], bias [130:99], zero fill [135:131]
  output      logic [lrsgd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lrsgd_pkg::LR_W-1:0]           cfg_wr_data
);
  import lrsgd_pkg::*;

  localparam int IDX_W = $clog2(SIG_ENTRIES);
  localparam int OFF_W = 20;
  localparam int ACC_W = 50;
  localparam int Z_W   = 36;
  localparam int G_W   = 35;

  // saturate to signed 32 bits
  function automatic logic signed [WGT_W-1:0] sat32(input logic signed [WGT_W+1:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[WGT_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [LR_W-1:0]          lr_r;
  logic signed [WGT_W-1:0]  w0_r, w1_r, b_r;
  logic [FEAT_W-1:0]        x0_r, x1_r;
  logic                     lab_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [OFF_W-1:0]         off_r;
  logic                     clamp_lo_r, clamp_hi_r;
  logic [IDX_W-1:0]         idx_r;
  logic [PROB_W-1:0]        p_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [G_W-1:0]    g_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_valid_r, out_valid_nxt;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod_r;

  logic                      advance;
  logic signed [Z_W-1:0]     z;
  logic signed [Z_W-1:0]     z_off;
  logic signed [ERR_W-1:0]   err;
  logic signed [MUL_P_W-1:0] dw_sum;
  logic signed [21:0]        dw;
  logic signed [G_W:0]       db_sum;
  logic signed [19:0]        db;
  logic signed [WGT_W-1:0]   w0_new, w1_new, b_new;

  logic [PROB_W-1:0] sig_lut [SIG_ENTRIES];

  // sigmoid table, constant at elaboration
  for (genvar k = 0; k < SIG_ENTRIES; k++) begin : g_lut
    assign sig_lut[k] = sig_entry(k, SIG_ENTRIES);
  end

  // shared multiplier
  lrsgd_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  // next step
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MZ0;
      ST_MZ0:  state_nxt = ST_MZ1;
      ST_MZ1:  state_nxt = ST_ZSUM;
      ST_ZSUM: state_nxt = ST_ZCLP;
      ST_ZCLP: state_nxt = ST_MIDX;
      ST_MIDX: state_nxt = ST_IDX;
      ST_IDX:  state_nxt = ST_LUT;
      ST_LUT:  state_nxt = ST_MG;
      ST_MG:   state_nxt = ST_MD0;
      ST_MD0:  state_nxt = ST_MD1;
      ST_MD1:  state_nxt = ST_UPD;
      ST_UPD:  if (advance) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and multiplier operand select
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    advance    = !out_valid_r || out_tready;
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    unique case (state_r)
      ST_MZ0: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(w0_r);
        mul_req.b  = $signed({1'b0, x0_r});
      end
      ST_MZ1: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(w1_r);
        mul_req.b  = $signed({1'b0, x1_r});
      end
      ST_MIDX: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed({{(MUL_A_W-OFF_W){1'b0}}, off_r});
        mul_req.b  = $signed(MUL_B_W'(SIG_ENTRIES));
      end
      ST_MG: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(err);
        mul_req.b  = $signed({1'b0, lr_r});
      end
      ST_MD0: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed(prod_r[MUL_A_W-1:0]);
        mul_req.b  = $signed({1'b0, x0_r});
      end
      ST_MD1: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(g_r);
        mul_req.b  = $signed({1'b0, x1_r});
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  // z with its offset into the table range
  assign z     = Z_W'($signed(acc_r[ACC_W-1:15])) + Z_W'(b_r);
  assign z_off = z + 36'sd524288;

  // error from the table output
  assign err = $signed({1'b0, p_r}) - (lab_r ? 18'sd65536 : 18'sd0);

  // rounded weight delta from the product register
  assign dw_sum = prod_r + 53'sd1073741824;
  assign dw     = dw_sum[52:31];

  // rounded bias delta
  assign db_sum = (G_W+1)'(g_r) + 36'sd32768;
  assign db     = db_sum[G_W:16];

  // saturated updates
  assign w0_new = sat32((WGT_W+2)'(w0_r) - (WGT_W+2)'(dw));
  assign w1_new = sat32((WGT_W+2)'(w1_r) - (WGT_W+2)'(dw));
  assign b_new  = sat32((WGT_W+2)'(b_r) - (WGT_W+2)'(db));

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_UPD && advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state, learning rate and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lr_r        <= LR_RESET;
      w0_r        <= WGT_RESET;
      w1_r        <= WGT_RESET;
      b_r         <= WGT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        lr_r <= cfg_wr_data;
      end
      if (state_r == ST_MD1) begin
        w0_r <= w0_new;
      end
      if (state_r == ST_UPD && advance) begin
        w1_r <= w1_new;
        b_r  <= b_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        x0_r  <= in_tdata[FEAT_W-1:0];
        x1_r  <= in_tdata[2*FEAT_W-1:FEAT_W];
        lab_r <= in_tuser;
      end
      ST_MZ1: begin
        acc_r <= $signed(prod_r[ACC_W-1:0]);
      end
      ST_ZSUM: begin
        acc_r <= acc_r + $signed(prod_r[ACC_W-1:0]);
      end
      ST_ZCLP: begin
        clamp_lo_r <= (z < -36'sd524288);
        clamp_hi_r <= (z >= 36'sd524288);
        off_r      <= z_off[OFF_W-1:0];
      end
      ST_IDX: begin
        priority if (clamp_lo_r) begin
          idx_r <= '0;
        end else if (clamp_hi_r) begin
          idx_r <= IDX_W'(SIG_ENTRIES - 1);
        end else begin
          idx_r <= prod_r[OFF_W +: IDX_W];
        end
      end
      ST_LUT: begin
        p_r <= sig_lut[idx_r];
      end
      ST_MG: begin
        err_r <= err;
      end
      ST_MD0: begin
        g_r <= prod_r[G_W-1:0];
      end
      ST_UPD: begin
        if (advance) begin
          out_data_r <= {5'b0, b_new, w1_new, w0_r, err_r, p_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lrsgd_mul.sv =====
`default_nettype none

module lrsgd_mul (
  input  wire logic                                  clk,
  input  wire lrsgd_pkg::mul_req_t                   req,
  output      logic signed [lrsgd_pkg::MUL_P_W-1:0]  prod_r
);
  import lrsgd_pkg::*;

  logic signed [MUL_P_W-1:0] prod_nxt;

  // signed product of the selected operands
  assign prod_nxt = MUL_P_W'(req.a) * MUL_P_W'(req.b);

  // product register, held when idle
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lrsgd_chk.sv =====
`default_nettype none

module lrsgd_chk (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tvalid,
  input wire logic                                 in_tready,
  input wire logic [lrsgd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready
);
  import lrsgd_pkg::*;

  logic [PROB_W-1:0]       prob;
  logic signed [ERR_W-1:0] err;

  assign prob = out_tdata[PROB_W-1:0];
  assign err  = $signed(out_tdata[PROB_W+ERR_W-1:PROB_W]);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  // probability stays within 0 to 1.0
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> prob <= 17'd65536)
    else $error("probability out of range");

  // error is the probability minus 0 or 1.0
  a_err_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (err == $signed({1'b0, prob})) ||
                   (err == $signed({1'b0, prob}) - 18'sd65536))
    else $error("error does not match probability");

endmodule

bind logistic_regression_sgd_step lrsgd_chk u_lrsgd_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tdata   (out_tdata),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready)
);

`default_nettype wire
